/* hw/rtl/lsp_pkg.sv */
package lsp_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = 7;
    localparam int POS_W       = 7;
    localparam int WORD_W      = 32;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_BITS  = 2 + WORD_W + POS_W;
    localparam int OUT_BITS = WORD_W + 2 + 1 + CNT_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Command codes.
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;    // capture a new command and update the stack
        logic load_out;  // move the finished result into the output register
    } t_ctrl;

endpackage

/* hw/rtl/lifo_stack_with_peek.sv */
// A command accepted in the idle state has its status, fill count and array read
// registered; the execute state then loads the result into the output register
// once the output side is free. No new command is taken until that load.
// Reset (synchronous, active low) empties the stack and drops any pending result;
// the entry array itself is not cleared, since only written entries are ever returned.
module lifo_stack_with_peek
    import lsp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Slave side: command transactions.
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // Fields from bit 0: command[1:0], value[33:2], position[40:34], zero pad.
    input  logic [IN_W-1:0]  s_axis_tdata,
    // Master side: one result transaction per command.
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // Fields from bit 0: read_value[31:0], status[33:32], is_empty[34],
    // entry_count[41:35], zero pad.
    output logic [OUT_W-1:0] m_axis_tdata
);

    t_ctrl             w_ctrl;
    logic [WORD_W-1:0] w_read_value;
    logic [1:0]        w_status;
    logic              w_is_empty;
    logic [CNT_W-1:0]  w_entry_count;

    // The controller sequences accept, array read and result load; the
    // datapath holds the fill count, the entry array and the output register.
    lsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_ctrl      (w_ctrl)
    );

    lsp_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_command     (s_axis_tdata[1:0]),
        .i_value       (s_axis_tdata[WORD_W+1:2]),
        .i_position    (s_axis_tdata[WORD_W+POS_W+1:WORD_W+2]),
        .o_read_value  (w_read_value),
        .o_status      (w_status),
        .o_is_empty    (w_is_empty),
        .o_entry_count (w_entry_count)
    );

    // Pack the result; the unused upper bits are zero.
    assign m_axis_tdata = {(OUT_W - OUT_BITS)'(0), w_entry_count, w_is_empty,
                           w_status, w_read_value};

`ifndef SYNTHESIS
    // A command is still in flight in the cycle after its transaction, so ready is low.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command accepted while one is in flight");

    // The reported count never exceeds the stack depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[WORD_W+3+CNT_W-1:WORD_W+3] <= CNT_W'(STACK_DEPTH)))
        else $error("entry count beyond stack depth");

    // The empty flag agrees with the count.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[WORD_W+2] ==
                           (m_axis_tdata[WORD_W+3+CNT_W-1:WORD_W+3] == '0)))
        else $error("empty flag does not match entry count");

    // A failed command always returns a zero word.
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[WORD_W+1:WORD_W] != ST_OK)
        |-> (m_axis_tdata[WORD_W-1:0] == '0))
        else $error("nonzero read value with error status");
`endif

endmodule

/* hw/rtl/lsp_ctrl.sv */
module lsp_ctrl
    import lsp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_ready,
    output logic  o_in_ready,
    output logic  o_out_valid,
    output t_ctrl o_ctrl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic w_accept;
    logic w_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    // The result leaves the execute state once the output register is free.
    assign w_load     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ctrl.accept   = w_accept;
    assign o_ctrl.load_out = w_load;

endmodule

/* hw/rtl/lsp_datapath.sv */
module lsp_datapath
    import lsp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctrl            i_ctrl,
    input  logic [1:0]       i_command,
    input  logic [WORD_W-1:0] i_value,
    input  logic [POS_W-1:0] i_position,
    output logic [WORD_W-1:0] o_read_value,
    output logic [1:0]       o_status,
    output logic             o_is_empty,
    output logic [CNT_W-1:0] o_entry_count
);

    logic [WORD_W-1:0] r_mem [STACK_DEPTH];
    logic [WORD_W-1:0] r_rd_data;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  n_fill;
    logic [1:0]        r_status;
    logic [1:0]        n_status;
    logic              r_peek_ok;
    logic              n_peek_ok;
    logic              w_write;
    logic [POS_W-1:0]  w_pos;
    logic [CNT_W-1:0]  w_rd_diff;

    logic [WORD_W-1:0] r_out_value;
    logic [1:0]        r_out_status;
    logic [CNT_W-1:0]  r_out_count;

    // Position zero is treated as the top of the stack.
    assign w_pos     = (i_position == '0) ? POS_W'(1) : i_position;
    assign w_rd_diff = r_fill - CNT_W'(w_pos);

    always_comb begin
        n_fill    = r_fill;
        n_status  = ST_OK;
        n_peek_ok = 1'b0;
        w_write   = 1'b0;
        case (i_command)
            CMD_PUSH: begin
                if (r_fill >= CNT_W'(STACK_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    w_write = 1'b1;
                    n_fill  = r_fill + CNT_W'(1);
                end
            end
            CMD_POP: begin
                if (r_fill == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_fill = r_fill - CNT_W'(1);
                end
            end
            CMD_PEEK: begin
                if (r_fill == '0) begin
                    n_status = ST_EMPTY;
                end else if (CNT_W'(w_pos) > r_fill) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_peek_ok = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Simple dual-port style array: one write at the fill level, one registered read.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept && w_write) begin
            r_mem[r_fill[ADDR_W-1:0]] <= i_value;
        end
        if (i_ctrl.accept) begin
            r_rd_data <= r_mem[w_rd_diff[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_ctrl.accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_status  <= n_status;
            r_peek_ok <= n_peek_ok;
        end
        if (i_ctrl.load_out) begin
            r_out_value  <= r_peek_ok ? r_rd_data : '0;
            r_out_status <= r_status;
            r_out_count  <= r_fill;
        end
    end

    assign o_read_value  = r_out_value;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;
    assign o_is_empty    = (r_out_count == '0);

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import lsp_pkg::*;

    // Spare command code. The block must answer it as a no-op with status ok.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int unsigned RANDOM_ITEMS = 1100;
    localparam int unsigned LONG_HOLD    = 120;
    localparam int unsigned LIMIT_CYCLES = 600000;
    localparam int unsigned TAIL_CYCLES  = 10;

    // One expected reply, unpacked from or compared against m_axis_tdata.
    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        logic [1:0]        status;
        logic              is_empty;
        logic [CNT_W-1:0]  entry_count;
    } t_stack_reply;

    // Keeps its own copy of the stack and a queue of the replies that the
    // accepted commands must produce, in order.
    class t_stack_scoreboard;
        logic [WORD_W-1:0] words [STACK_DEPTH];
        int unsigned       held;
        t_stack_reply      waiting [$];
        int unsigned       checked;
        int unsigned       mismatches;
        int unsigned       status_hits [4];
        int unsigned       times_full;

        function void note_command(logic [IN_W-1:0] tdata);
            logic [1:0]        cmd;
            logic [WORD_W-1:0] word;
            int unsigned       depth;
            t_stack_reply      r;
            cmd   = tdata[1:0];
            word  = tdata[33:2];
            depth = 32'(tdata[40:34]);
            r     = '0;
            r.status = ST_OK;
            case (cmd)
                CMD_PUSH: begin
                    if (held >= STACK_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        words[held] = word;
                        held++;
                        if (held == STACK_DEPTH) times_full++;
                    end
                end
                CMD_POP: begin
                    if (held == 0) r.status = ST_EMPTY;
                    else held--;
                end
                CMD_PEEK: begin
                    // Position zero is an alias for the top entry.
                    if (depth == 0) depth = 1;
                    if (held == 0) r.status = ST_EMPTY;
                    else if (depth > held) r.status = ST_BADPOS;
                    else r.read_value = words[held - depth];
                end
                default: ;
            endcase
            r.is_empty    = (held == 0);
            r.entry_count = CNT_W'(held);
            waiting.push_back(r);
        endfunction

        function void check_result(logic [OUT_W-1:0] tdata);
            t_stack_reply want;
            t_stack_reply got;
            got.read_value  = tdata[31:0];
            got.status      = tdata[33:32];
            got.is_empty    = tdata[34];
            got.entry_count = tdata[41:35];
            if (waiting.size() == 0) begin
                $error("Result transaction with no command outstanding: %h", tdata);
                mismatches++;
                return;
            end
            want = waiting.pop_front();
            checked++;
            status_hits[want.status]++;
            if (got.read_value !== want.read_value) begin
                $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.is_empty !== want.is_empty) begin
                $error("is_empty: expected %0b, actual %0b", want.is_empty, got.is_empty);
                mismatches++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, actual %0d",
                       want.entry_count, got.entry_count);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return waiting.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;   // command, value, position, zero pad
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;   // read_value, status, is_empty, entry_count, pad

    t_stack_scoreboard sb = new();

    // Stimulus bookkeeping, owned by the main stimulus process.
    int unsigned       sent_items;
    int unsigned       depth_guess;
    bit                gaps_on;
    int unsigned       long_hold_requests;

    lifo_stack_with_peek i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Both monitors sample at the rising edge, so they see the values that
    // the handshake was decided on.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_command(s_axis_tdata);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // Idle length: half the time none, mostly short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one command, waits for the transaction, then maybe idles.
    task automatic issue(input logic [1:0] cmd, input logic [WORD_W-1:0] word,
                         input logic [POS_W-1:0] pos);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - 2 - WORD_W - POS_W){1'b0}}, pos, word, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
        if (cmd == CMD_PUSH && depth_guess < STACK_DEPTH) depth_guess++;
        if (cmd == CMD_POP && depth_guess > 0) depth_guess--;
        gap = gaps_on ? pick_gap() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Position aimed mostly at live entries and just past them.
    function automatic logic [POS_W-1:0] pick_position();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7) return POS_W'($urandom_range(0, depth_guess + 1));
        if (r < 9) return '0;
        return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    endfunction

    task automatic issue_random();
        int unsigned r;
        logic [1:0]  cmd;
        r = $urandom_range(0, 99);
        if (r < 40) cmd = CMD_PUSH;
        else if (r < 65) cmd = CMD_POP;
        else if (r < 97) cmd = CMD_PEEK;
        else cmd = CMD_SPARE;
        issue(cmd, $urandom(), pick_position());
    endtask

    // Sender stops offering until every outstanding reply has been checked.
    // The first edge lets the monitor record a command accepted just now.
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Receiver: random ready pattern, plus a long hold-off on request so that
    // the block fills its output stage and back-pressures the command side.
    initial begin
        int unsigned holds_done;
        int unsigned run;
        holds_done = 0;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (holds_done < long_hold_requests) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                holds_done++;
            end else begin
                m_axis_tready <= 1'b1;
                run = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 4);
                repeat (run) @(posedge i_clk);
                run = pick_gap();
                if (run != 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (run) @(posedge i_clk);
                end
            end
        end
    end

    // Main stimulus: reset, a directed pass over the corner cases, then
    // random phases of fill, drain, mixed traffic and peek sweeps.
    initial begin
        int unsigned phase;
        int unsigned kind;
        int unsigned n;
        int unsigned p;
        sent_items         = 0;
        depth_guess        = 0;
        gaps_on            = 1'b1;
        long_hold_requests <= 0;
        i_rst_n            <= 1'b0;
        s_axis_tvalid      <= 1'b0;
        s_axis_tdata       <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-stack answers, word extremes, every position corner,
        // the spare command code and pops back down.
        issue(CMD_POP,  32'h0000_0000, 7'd0);
        issue(CMD_PEEK, 32'hFFFF_FFFF, 7'd0);
        issue(CMD_PEEK, 32'h0000_0000, 7'd127);
        issue(CMD_PUSH, 32'h8000_0000, 7'd0);
        issue(CMD_PUSH, 32'h7FFF_FFFF, 7'd127);
        issue(CMD_PUSH, 32'hFFFF_FFFF, 7'd0);
        issue(CMD_PUSH, 32'h0000_0000, 7'd0);
        issue(CMD_PUSH, 32'h5555_5555, 7'd0);
        issue(CMD_PUSH, 32'hAAAA_AAAA, 7'd0);
        issue(CMD_PEEK, 32'h0000_0000, 7'd0);
        issue(CMD_PEEK, 32'h0000_0000, 7'd1);
        issue(CMD_PEEK, 32'h0000_0000, 7'd2);
        issue(CMD_PEEK, 32'h0000_0000, 7'd6);
        issue(CMD_PEEK, 32'h0000_0000, 7'd7);
        issue(CMD_PEEK, 32'h0000_0000, 7'd64);
        issue(CMD_PEEK, 32'h0000_0000, 7'd127);
        issue(CMD_SPARE, 32'hFFFF_FFFF, 7'd127);
        issue(CMD_SPARE, 32'h0000_0000, 7'd0);
        issue(CMD_POP,  32'hFFFF_FFFF, 7'd127);
        issue(CMD_POP,  32'h0000_0000, 7'd0);
        issue(CMD_PEEK, 32'h0000_0000, 7'd4);
        issue(CMD_PEEK, 32'h0000_0000, 7'd5);

        phase = 0;
        while (sent_items < RANDOM_ITEMS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            // Two forced back-pressure episodes with the sender running flat out.
            if (phase == 1 || phase == 6) begin
                long_hold_requests <= long_hold_requests + 1;
                gaps_on = 1'b0;
            end
            if (phase == 3 || $urandom_range(0, 7) == 0) pause_until_drained();
            kind = $urandom_range(0, 4);
            case (kind)
                0: begin
                    // Fill to the top, then a few refused pushes.
                    while (depth_guess < STACK_DEPTH) begin
                        if ($urandom_range(0, 7) == 0) issue(CMD_PEEK, $urandom(), pick_position());
                        else issue(CMD_PUSH, $urandom(), pick_position());
                    end
                    n = $urandom_range(1, 3);
                    repeat (n) issue(CMD_PUSH, $urandom(), pick_position());
                    issue(CMD_PEEK, $urandom(), POS_W'(STACK_DEPTH));
                end
                1: begin
                    // Drain to empty, then pops and a peek on the empty stack.
                    while (depth_guess > 0) begin
                        if ($urandom_range(0, 7) == 0) issue(CMD_PEEK, $urandom(), pick_position());
                        else issue(CMD_POP, $urandom(), pick_position());
                    end
                    n = $urandom_range(1, 2);
                    repeat (n) issue(CMD_POP, $urandom(), pick_position());
                    issue(CMD_PEEK, $urandom(), pick_position());
                end
                2, 3: begin
                    n = $urandom_range(20, 60);
                    repeat (n) issue_random();
                end
                default: begin
                    // Walk every depth from the top, plus one past the bottom.
                    n = depth_guess + 1;
                    for (p = 0; p <= n; p++) issue(CMD_PEEK, $urandom(), POS_W'(p));
                end
            endcase
            phase++;
        end

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected replies never arrived", sb.pending());
            sb.mismatches++;
        end

        $display("Checked %0d replies to %0d commands; the stack ran full %0d times.",
                 sb.checked, sent_items, sb.times_full);
        $display("Replies by status: ok %0d, empty %0d, position beyond entries %0d, full %0d.",
                 sb.status_hits[ST_OK], sb.status_hits[ST_EMPTY],
                 sb.status_hits[ST_BADPOS], sb.status_hits[ST_FULL]);
        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
